// File: rtl/core/positional_array_list_defines.svh
// Assertion macros for the positional array list.
// Used by positional_array_list.sv; expects clk and rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pal_pkg.sv
// Shared types and codes for the positional array list.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pal_pkg;

    // Request action codes
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_READ   = 3'd3,
        ACT_APPEND = 3'd4
    } action_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECT   = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PUT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  position;
        logic [31:0] element;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  found_index;
        logic [31:0] read_element;
        logic [6:0]  entry_count;
    } rsp_word_t;

endpackage

`default_nettype wire

// File: rtl/core/pal_chan_if.sv
// Valid/ready channels for list requests and responses.
// Depends on pal_pkg for the word types.
`default_nettype none

interface pal_req_if;
    import pal_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pal_rsp_if;
    import pal_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/positional_array_list.sv
// Positional array list: ordered word store with insert, delete, search, read, append.
// Depends on pal_pkg, pal_chan_if.sv and positional_array_list_defines.svh.
//
//   channel | dir | word fields
//   req     | in  | action, position, element
//   rsp     | out | status, found_index, read_element, entry_count
//
// One request at a time; req.ready is high only while idle.
// Entries live in a single RAM with one read and one write port; shifts and searches
// walk it one entry per cycle, pipelined through the registered read data.
// Reset clears the count, the sequencer state and the read-valid flag only; the RAM needs no clearing.
// A response waiting on rsp.ready holds the block in its response state.
`default_nettype none

module positional_array_list #(
    parameter int DEPTH  = 64,
    parameter int ELEM_W = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);
    import pal_pkg::*;
    `include "positional_array_list_defines.svh"

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = (CNT_W > 7) ? CNT_W : 7;
    localparam int EXT_W = (ELEM_W > 32) ? ELEM_W : 32;

    // RAM
    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ELEM_W-1:0] wr_data;

    // Control and working registers
    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW-1:0]     last_reg, last_next;
    logic              pv_reg, pv_next;
    logic [AW-1:0]     pa_reg, pa_next;
    status_t           status_reg, status_next;
    logic [AW-1:0]     found_reg, found_next;
    logic [ELEM_W-1:0] rd_reg, rd_next;

    // Widened views for compares and port widths
    logic [W-1:0]      pos_x, cnt_x, depth_x, found_x, cnt_out_x;
    logic [EXT_W-1:0]  elem_in_x, rd_x;
    logic [CNT_W-1:0]  cnt_m1;
    logic              req_fire;
    logic              hit;

    assign pos_x     = W'(req.data.position);
    assign cnt_x     = W'(count_reg);
    assign depth_x   = W'(DEPTH);
    assign found_x   = W'(found_reg);
    assign cnt_out_x = W'(count_reg);
    assign elem_in_x = EXT_W'(req.data.element);
    assign rd_x      = EXT_W'(rd_reg);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign req_fire  = req.valid && req.ready;
    assign hit       = (rdata_reg == elem_reg);

    // Ports
    assign req.ready             = (state_reg == S_IDLE);
    assign rsp.valid             = (state_reg == S_RESP);
    assign rsp.data.status       = status_reg;
    assign rsp.data.found_index  = found_x[5:0];
    assign rsp.data.read_element = rd_x[31:0];
    assign rsp.data.entry_count  = cnt_out_x[6:0];

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pv_reg    <= pv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        rp_reg     <= rp_next;
        last_reg   <= last_next;
        pa_reg     <= pa_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rd_reg     <= rd_next;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        count_next  = count_reg;
        rp_next     = rp_reg;
        last_next   = last_reg;
        pv_next     = pv_reg;
        pa_next     = pa_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rd_next     = rd_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = elem_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    act_next    = action_t'(req.data.action);
                    pos_next    = pos_x[AW-1:0];
                    elem_next   = elem_in_x[ELEM_W-1:0];
                    found_next  = '0;
                    rd_next     = '0;
                    pv_next     = 1'b0;
                    status_next = ST_REJECT;
                    state_next  = S_RESP;
                    unique case (req.data.action)
                        ACT_INSERT:
                        begin
                            if (cnt_x < depth_x && pos_x <= cnt_x)
                            begin
                                status_next = ST_DONE;
                                if (pos_x < cnt_x)
                                begin
                                    // shift entries pos..count-1 up, top first
                                    rp_next    = cnt_m1[AW-1:0];
                                    last_next  = pos_x[AW-1:0];
                                    state_next = S_SCAN;
                                end
                                else
                                begin
                                    state_next = S_PUT;
                                end
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                status_next = ST_DONE;
                                if (pos_x + W'(1) < cnt_x)
                                begin
                                    rp_next    = pos_x[AW-1:0] + AW'(1);
                                    last_next  = cnt_m1[AW-1:0];
                                    state_next = S_SCAN;
                                end
                                else
                                begin
                                    count_next = cnt_m1;
                                end
                            end
                        end
                        ACT_SEARCH:
                        begin
                            status_next = ST_NOTFOUND;
                            if (cnt_x != '0)
                            begin
                                rp_next    = '0;
                                last_next  = cnt_m1[AW-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                status_next = ST_DONE;
                                rp_next     = pos_x[AW-1:0];
                                last_next   = pos_x[AW-1:0];
                                state_next  = S_SCAN;
                            end
                        end
                        ACT_APPEND:
                        begin
                            if (cnt_x < depth_x)
                            begin
                                status_next = ST_DONE;
                                pos_next    = count_reg[AW-1:0];
                                state_next  = S_PUT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_REJECT;
                        end
                    endcase
                end
            end

            S_SCAN, S_DRAIN:
            begin
                // issue the next read while scanning
                if (state_reg == S_SCAN)
                begin
                    rd_en   = 1'b1;
                    pv_next = 1'b1;
                    pa_next = rp_reg;
                    if (rp_reg == last_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else if (act_reg == ACT_INSERT)
                    begin
                        rp_next = rp_reg - AW'(1);
                    end
                    else
                    begin
                        rp_next = rp_reg + AW'(1);
                    end
                end
                else
                begin
                    pv_next = 1'b0;
                    case (act_reg)
                        ACT_INSERT: state_next = S_PUT;
                        ACT_DELETE:
                        begin
                            count_next = cnt_m1;
                            state_next = S_RESP;
                        end
                        default:    state_next = S_RESP;
                    endcase
                end

                // consume the word read last cycle
                if (pv_reg)
                begin
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pa_reg + AW'(1);
                            wr_data = rdata_reg;
                        end
                        ACT_DELETE:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pa_reg - AW'(1);
                            wr_data = rdata_reg;
                        end
                        ACT_SEARCH:
                        begin
                            if (hit)
                            begin
                                status_next = ST_DONE;
                                found_next  = pa_reg;
                                pv_next     = 1'b0;
                                state_next  = S_RESP;
                            end
                        end
                        ACT_READ:
                        begin
                            rd_next = rdata_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = elem_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `PAL_ASSERT_NOW(a_count_bound, 1'b1, (W'(count_reg) <= depth_x), "count exceeds depth")
    `PAL_ASSERT_NEXT(a_count_idle, (state_reg == S_IDLE && !req_fire), $stable(count_reg), "count moved while idle")
    `PAL_ASSERT_NOW(a_write_busy, wr_en, (state_reg == S_SCAN || state_reg == S_DRAIN || state_reg == S_PUT), "RAM write outside a walk")
    `PAL_ASSERT_NOW(a_notfound_zero, (rsp.valid && status_reg == ST_NOTFOUND), (found_reg == '0 && rd_reg == '0), "miss with nonzero fields")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for positional_array_list: random and directed list requests.
// Depends on pal_pkg, pal_chan_if.sv and the positional_array_list RTL; reads nothing else.
// Responses are checked field by field against an in-bench model of the list store.
module testbench;
    import pal_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int ELEM_BITS      = 32;
    localparam int RANDOM_TARGET  = 1875;
    localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    // action codes the block does not define
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

    // request mix of a random phase
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;
    localparam int MODE_NOISE = 3;

    typedef struct {
        req_word_t word;
        bit        wait_idle;   // hold this word back until every response is in
    } stim_t;

    logic clk;
    logic rst_n;

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list #(
        .DEPTH  (LIST_DEPTH),
        .ELEM_W (ELEM_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // pending request words and the responses they must produce
    stim_t       stim_q[$];
    rsp_word_t   expected_rsps[$];
    logic [31:0] elem_pool[$];

    // model of the list store, advanced at each accepted request
    logic [31:0] list_mem [LIST_DEPTH];
    int          list_len = 0;

    // list length as seen by the generator while it builds the stimulus
    int gen_len = 0;
    int total_words = 0;

    int issued_total = 0;
    int returned_total = 0;
    int mismatches = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit just_sent;
    rsp_word_t want;

    // expected response for one request; updates the list model
    function automatic rsp_word_t apply_request(req_word_t r);
        rsp_word_t o;
        int        k;
        bit        hit;
        o = '0;
        o.status = ST_REJECT;
        hit = 1'b0;
        case (r.action)
            ACT_INSERT:
                if (list_len < LIST_DEPTH && r.position <= list_len) begin
                    for (k = list_len; k > r.position; k--)
                        list_mem[k] = list_mem[k - 1];
                    list_mem[r.position] = r.element;
                    list_len++;
                    o.status = ST_DONE;
                end
            ACT_DELETE:
                if (r.position < list_len) begin
                    for (k = r.position; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_len--;
                    o.status = ST_DONE;
                end
            ACT_SEARCH:
            begin
                o.status = ST_NOTFOUND;
                for (k = 0; k < list_len && !hit; k++) begin
                    if (list_mem[k] == r.element) begin
                        hit = 1'b1;
                        o.status = ST_DONE;
                        o.found_index = k[5:0];
                    end
                end
            end
            ACT_READ:
                if (r.position < list_len) begin
                    o.read_element = list_mem[r.position];
                    o.status = ST_DONE;
                end
            ACT_APPEND:
                if (list_len < LIST_DEPTH) begin
                    list_mem[list_len] = r.element;
                    list_len++;
                    o.status = ST_DONE;
                end
            default: ;
        endcase
        o.entry_count = list_len[6:0];
        return o;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // element word: recent values for hits and duplicates, corners, or random
    function automatic logic [31:0] pick_element();
        int r = $urandom_range(0, 99);
        if (r < 35 && elem_pool.size() > 0)
            return elem_pool[$urandom_range(0, elem_pool.size() - 1)];
        if (r < 40)
            return 32'hFFFF_FFFF;
        if (r < 45)
            return 32'h1 << $urandom_range(0, 31);
        if (r < 50)
            return $urandom_range(0, 3);
        return $urandom;
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want_v, got_v);
            mismatches++;
        end
    endfunction

    task automatic add_item(input logic [2:0] act, input int pos, input logic [31:0] el,
                            input bit wait_idle);
        stim_t s;
        s.word.action   = act;
        s.word.position = pos[5:0];
        s.word.element  = el;
        s.wait_idle     = wait_idle;
        stim_q.push_back(s);
        // track the length so later positions stay mostly in range
        case (act)
            ACT_INSERT:
                if (gen_len < LIST_DEPTH && pos <= gen_len) begin
                    gen_len++;
                    elem_pool.push_back(el);
                end
            ACT_DELETE:
                if (pos < gen_len)
                    gen_len--;
            ACT_APPEND:
                if (gen_len < LIST_DEPTH) begin
                    gen_len++;
                    elem_pool.push_back(el);
                end
            default: ;
        endcase
        if (elem_pool.size() > 48)
            void'(elem_pool.pop_front());
    endtask

    task automatic gen_item(input int mode, input bit wait_idle);
        int         r;
        int         pos;
        logic [2:0] act;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                act = (r < 45) ? ACT_APPEND : (r < 80) ? ACT_INSERT :
                      (r < 90) ? ACT_SEARCH : ACT_READ;
            MODE_DRAIN:
                act = (r < 70) ? ACT_DELETE : (r < 85) ? ACT_SEARCH : ACT_READ;
            MODE_MIX:
                act = (r < 20) ? ACT_INSERT : (r < 40) ? ACT_DELETE :
                      (r < 60) ? ACT_SEARCH : (r < 80) ? ACT_READ : ACT_APPEND;
            default:
                act = 3'($urandom_range(0, 7));
        endcase
        // noise takes any position; otherwise stay within the list
        if (mode == MODE_NOISE)
            pos = $urandom_range(0, 63);
        else if (act == ACT_INSERT)
            pos = $urandom_range(0, (gen_len < LIST_DEPTH) ? gen_len : LIST_DEPTH - 1);
        else if (gen_len > 0)
            pos = $urandom_range(0, gen_len - 1);
        else
            pos = 0;
        add_item(act, pos, pick_element(), wait_idle);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // stimulus, reset and end of run
    initial
    begin
        int  phase;
        bit  idle_first;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;

        // directed: empty list, edges of position and element, unknown actions
        add_item(ACT_SEARCH, 0, 32'h0, 1'b0);
        add_item(ACT_READ, 0, 32'h0, 1'b0);
        add_item(ACT_DELETE, 0, 32'h0, 1'b0);
        add_item(ACT_INSERT, 1, 32'h1234_5678, 1'b0);
        add_item(ACT_INSERT, 0, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_APPEND, 0, 32'h0, 1'b0);
        add_item(ACT_INSERT, 2, 32'hA5A5_A5A5, 1'b0);
        add_item(ACT_INSERT, 0, 32'h5A5A_5A5A, 1'b0);
        add_item(ACT_INSERT, 63, 32'h8000_0001, 1'b0);
        add_item(ACT_READ, 0, 32'h0, 1'b0);
        add_item(ACT_READ, 3, 32'h0, 1'b0);
        add_item(ACT_READ, 4, 32'h0, 1'b0);
        add_item(ACT_READ, 63, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_SEARCH, 0, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_SEARCH, 0, 32'h0, 1'b0);
        add_item(ACT_SEARCH, 0, 32'h1234_5678, 1'b0);
        add_item(ACT_UNUSED_LO, 0, 32'h0, 1'b0);
        add_item(ACT_UNUSED_MID, 1, 32'hA5A5_A5A5, 1'b0);
        add_item(ACT_UNUSED_HI, 63, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_DELETE, 63, 32'h0, 1'b0);
        add_item(ACT_DELETE, 0, 32'h0, 1'b0);
        add_item(ACT_DELETE, 2, 32'h0, 1'b0);
        add_item(ACT_APPEND, 0, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_SEARCH, 0, 32'hFFFF_FFFF, 1'b0);
        add_item(ACT_DELETE, 4, 32'h0, 1'b0);

        // random phases: fill to full, drain to empty, mixed traffic, noise
        idle_first = 1'b1;
        while (stim_q.size() < RANDOM_TARGET + 25) begin
            phase = $urandom_range(0, 9);
            if (phase < 3) begin
                while (gen_len < LIST_DEPTH) begin
                    gen_item(MODE_FILL, idle_first);
                    idle_first = 1'b0;
                end
                repeat ($urandom_range(1, 3)) gen_item(MODE_FILL, 1'b0);
            end
            else if (phase < 6) begin
                while (gen_len > 0) begin
                    gen_item(MODE_DRAIN, idle_first);
                    idle_first = 1'b0;
                end
                repeat ($urandom_range(1, 3)) gen_item(MODE_DRAIN, 1'b0);
            end
            else if (phase < 9) begin
                repeat ($urandom_range(30, 120)) begin
                    gen_item(MODE_MIX, idle_first);
                    idle_first = 1'b0;
                end
            end
            else begin
                repeat ($urandom_range(10, 30)) begin
                    gen_item(MODE_NOISE, idle_first);
                    idle_first = 1'b0;
                end
            end
            idle_first = ($urandom_range(0, 2) == 0);
        end
        total_words = stim_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (issued_total != total_words || returned_total != total_words)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0)
            $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** positional_array_list: PASSED **");
        else
            $display("** positional_array_list: FAILED **");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
            send_gap = 0;
        end
        else begin
            just_sent = 1'b0;
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(apply_request(req_ch.data));
                void'(stim_q.pop_front());
                issued_total <= issued_total + 1;
                just_sent = 1'b1;
                // gap-free stretches every so often
                send_gap = (((issued_total / 160) % 3) == 1) ? 0 : pick_gap();
            end
            if (req_ch.valid && !req_ch.ready) begin
                // word stays on the bus until taken
            end
            else if (send_gap > 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (stim_q.size() > 0 && (!stim_q[0].wait_idle ||
                     (!just_sent && issued_total == returned_total))) begin
                req_ch.valid <= 1'b1;
                req_ch.data <= stim_q[0].word;
            end
            else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %0h",
                             $time, rsp_ch.data);
                    mismatches++;
                end
                else begin
                    want = expected_rsps.pop_front();
                    check_field("status", want.status, rsp_ch.data.status);
                    check_field("found_index", want.found_index, rsp_ch.data.found_index);
                    check_field("read_element", want.read_element, rsp_ch.data.read_element);
                    check_field("entry_count", want.entry_count, rsp_ch.data.entry_count);
                end
                returned_total <= returned_total + 1;
                // long hold-off so the block backs up onto its request side
                if (returned_total == 700 || returned_total == 1500)
                    hold_left = HOLD_CYCLES;
                recv_gap = (((returned_total / 190) % 3) == 2) ? 0 : pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0) begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("** positional_array_list: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_chan_if.sv
rtl/core/positional_array_list.sv
tb/testbench.sv
